[src/spq_pkg.sv]
// Shared constants, operation codes and cell control type of the stable priority queue.
package spq_pkg;

    localparam int DEF_CAPACITY      = 64;
    localparam int DEF_PRIORITY_BITS = 16;
    localparam int DEF_PAYLOAD_BITS  = 32;

    localparam int FUNC_BITS = 2;
    localparam logic [FUNC_BITS-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

    // Control handed from the sequencer to every cell of the chain.
    typedef struct packed {
        logic load;   // push write: the cell whose index equals the count takes the item
        logic shift;  // pop close-up: cells at or above the removed index take their neighbor
        logic desc;   // serve largest key first
    } t_cell_ctl;

endpackage

[src/spq_cell.sv]
// One queue slot: entry storage, close-up shift and one stage of the front/back scan wave.
module spq_cell #(
    parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
    parameter int PAYLOAD_BITS  = spq_pkg::DEF_PAYLOAD_BITS,
    parameter int IDX           = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  spq_pkg::t_cell_ctl                 i_ctl,
    input  logic [$clog2(CAPACITY+1)-1:0]      i_count,
    input  logic [$clog2(CAPACITY)-1:0]        i_rm_idx,
    input  logic [PRIORITY_BITS-1:0]           i_push_key,
    input  logic [PAYLOAD_BITS-1:0]            i_push_pay,
    input  logic [PRIORITY_BITS-1:0]           i_nb_key,
    input  logic [PAYLOAD_BITS-1:0]            i_nb_pay,
    output logic [PRIORITY_BITS-1:0]           o_key,
    output logic [PAYLOAD_BITS-1:0]            o_pay,
    // scan wave in
    input  logic                               i_tv,
    input  logic                               i_th,
    input  logic [PRIORITY_BITS-1:0]           i_fk,
    input  logic [PAYLOAD_BITS-1:0]            i_fp,
    input  logic [$clog2(CAPACITY)-1:0]        i_fi,
    input  logic [PRIORITY_BITS-1:0]           i_bk,
    input  logic [PAYLOAD_BITS-1:0]            i_bp,
    // scan wave out
    output logic                               o_tv,
    output logic                               o_th,
    output logic [PRIORITY_BITS-1:0]           o_fk,
    output logic [PAYLOAD_BITS-1:0]            o_fp,
    output logic [$clog2(CAPACITY)-1:0]        o_fi,
    output logic [PRIORITY_BITS-1:0]           o_bk,
    output logic [PAYLOAD_BITS-1:0]            o_bp
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [IW-1:0] IDX_I = IW'(IDX);

    logic [PRIORITY_BITS-1:0] r_key;
    logic [PAYLOAD_BITS-1:0]  r_pay;
    logic                     r_tv;
    logic                     r_th;
    logic [PRIORITY_BITS-1:0] r_fk;
    logic [PAYLOAD_BITS-1:0]  r_fp;
    logic [IW-1:0]            r_fi;
    logic [PRIORITY_BITS-1:0] r_bk;
    logic [PAYLOAD_BITS-1:0]  r_bp;

    logic w_live;
    logic w_f_before;
    logic w_b_before;
    logic w_take_f;
    logic w_take_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_count == IDX_C)) begin
            r_key <= i_push_key;
            r_pay <= i_push_pay;
        end else if (i_ctl.shift && (IDX_I >= i_rm_idx)) begin
            r_key <= i_nb_key;
            r_pay <= i_nb_pay;
        end
    end

    // served-before compare against the best so far; ties keep the earlier slot for
    // the front and move to the later slot for the back
    assign w_live     = IDX_C < i_count;
    assign w_f_before = i_ctl.desc ? (r_key > i_fk) : (r_key < i_fk);
    assign w_b_before = i_ctl.desc ? (r_key > i_bk) : (r_key < i_bk);
    assign w_take_f   = w_live && (!i_th || w_f_before);
    assign w_take_b   = w_live && (!i_th || !w_b_before);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else begin
            r_tv <= i_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_th <= i_th | w_live;
        r_fk <= w_take_f ? r_key : i_fk;
        r_fp <= w_take_f ? r_pay : i_fp;
        r_fi <= w_take_f ? IDX_I : i_fi;
        r_bk <= w_take_b ? r_key : i_bk;
        r_bp <= w_take_b ? r_pay : i_bp;
    end

    assign o_key = r_key;
    assign o_pay = r_pay;
    assign o_tv  = r_tv;
    assign o_th  = r_th;
    assign o_fk  = r_fk;
    assign o_fp  = r_fp;
    assign o_fi  = r_fi;
    assign o_bk  = r_bk;
    assign o_bp  = r_bp;

endmodule

[src/stable_priority_queue_unit.sv]
// Stable priority queue: CAPACITY entries held in arrival order in a chain of cells; each
// item (push, pop, clear) gives one result with the popped entry, the new front and back
// entries, the count and an empty flag. Equal keys leave in arrival order. i_cfg_data
// selects serving order (0 smallest key first, 1 largest first) and must be written only while
// the block is idle; the block itself does not enforce this. The scan wave walks the cell
// chain one cell per cycle: a push, clear, failed pop or unused code runs it once, while a
// successful pop runs the wave twice (find, close up, rescan). One item is in work at a
// time; the next is accepted as soon as the previous result sits in the output register,
// even if downstream is still stalling it.
module stable_priority_queue_unit #(
    parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
    parameter int PAYLOAD_BITS  = spq_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    // item in
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [spq_pkg::FUNC_BITS-1:0] i_func,
    input  logic [PRIORITY_BITS-1:0]      i_in_priority,
    input  logic [PAYLOAD_BITS-1:0]       i_in_payload,
    // result out
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_ok,
    output logic [PRIORITY_BITS-1:0]      o_out_priority,
    output logic [PAYLOAD_BITS-1:0]       o_out_payload,
    output logic [PRIORITY_BITS-1:0]      o_front_priority,
    output logic [PAYLOAD_BITS-1:0]       o_front_payload,
    output logic [PRIORITY_BITS-1:0]      o_back_priority,
    output logic [PAYLOAD_BITS-1:0]       o_back_payload,
    output logic [$clog2(CAPACITY+1)-1:0] o_count,
    output logic                          o_empty_res
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // IDLE: waiting for an item. FIND: wave looking for the entry to pop.
    // SHIFT: cells close the gap. SCAN: wave for the new front/back.
    // DONE: result waits for the output register.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SHIFT,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic                     r_desc;
    logic                     r_launch;
    logic [CW-1:0]            r_count;
    logic [IW-1:0]            r_rm_idx;
    logic                     r_ok;
    logic [PRIORITY_BITS-1:0] r_pop_key;
    logic [PAYLOAD_BITS-1:0]  r_pop_pay;
    logic [PRIORITY_BITS-1:0] r_fk;
    logic [PAYLOAD_BITS-1:0]  r_fp;
    logic [PRIORITY_BITS-1:0] r_bk;
    logic [PAYLOAD_BITS-1:0]  r_bp;

    // output register
    logic                     r_ov;
    logic                     r_o_ok;
    logic [PRIORITY_BITS-1:0] r_o_pk;
    logic [PAYLOAD_BITS-1:0]  r_o_pp;
    logic [PRIORITY_BITS-1:0] r_o_fk;
    logic [PAYLOAD_BITS-1:0]  r_o_fp;
    logic [PRIORITY_BITS-1:0] r_o_bk;
    logic [PAYLOAD_BITS-1:0]  r_o_bp;
    logic [CW-1:0]            r_o_count;
    logic                     r_o_empty;

    t_cell_ctl w_ctl;
    logic      w_in_acc;
    logic      w_out_free;

    // chain wiring: wave position i feeds cell i, cell i drives position i+1
    logic                     w_tv [CAPACITY+1];
    logic                     w_th [CAPACITY+1];
    logic [PRIORITY_BITS-1:0] w_fk [CAPACITY+1];
    logic [PAYLOAD_BITS-1:0]  w_fp [CAPACITY+1];
    logic [IW-1:0]            w_fi [CAPACITY+1];
    logic [PRIORITY_BITS-1:0] w_bk [CAPACITY+1];
    logic [PAYLOAD_BITS-1:0]  w_bp [CAPACITY+1];
    logic [PRIORITY_BITS-1:0] w_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0]  w_pay [CAPACITY];

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_ov || !i_out_stall;

    // push writes the free slot in the accept cycle itself
    assign w_ctl.load  = w_in_acc && (i_func == FUNC_PUSH) && (r_count < CAP_C);
    assign w_ctl.shift = (r_state == S_SHIFT);
    assign w_ctl.desc  = r_desc;

    // wave enters cell 0 with nothing seen yet
    assign w_tv[0] = r_launch;
    assign w_th[0] = 1'b0;
    assign w_fk[0] = '0;
    assign w_fp[0] = '0;
    assign w_fi[0] = '0;
    assign w_bk[0] = '0;
    assign w_bp[0] = '0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [PRIORITY_BITS-1:0] w_nb_key;
        logic [PAYLOAD_BITS-1:0]  w_nb_pay;

        if (gi == CAPACITY - 1) begin : g_end
            assign w_nb_key = '0;
            assign w_nb_pay = '0;
        end else begin : g_mid
            assign w_nb_key = w_key[gi+1];
            assign w_nb_pay = w_pay[gi+1];
        end

        spq_cell #(
            .CAPACITY      (CAPACITY),
            .PRIORITY_BITS (PRIORITY_BITS),
            .PAYLOAD_BITS  (PAYLOAD_BITS),
            .IDX           (gi)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_count    (r_count),
            .i_rm_idx   (r_rm_idx),
            .i_push_key (i_in_priority),
            .i_push_pay (i_in_payload),
            .i_nb_key   (w_nb_key),
            .i_nb_pay   (w_nb_pay),
            .o_key      (w_key[gi]),
            .o_pay      (w_pay[gi]),
            .i_tv       (w_tv[gi]),
            .i_th       (w_th[gi]),
            .i_fk       (w_fk[gi]),
            .i_fp       (w_fp[gi]),
            .i_fi       (w_fi[gi]),
            .i_bk       (w_bk[gi]),
            .i_bp       (w_bp[gi]),
            .o_tv       (w_tv[gi+1]),
            .o_th       (w_th[gi+1]),
            .o_fk       (w_fk[gi+1]),
            .o_fp       (w_fp[gi+1]),
            .o_fi       (w_fi[gi+1]),
            .o_bk       (w_bk[gi+1]),
            .o_bp       (w_bp[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_desc   <= 1'b0;
            r_launch <= 1'b0;
            r_count  <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_desc <= i_cfg_data;
            end

            // output handshake; DONE below overrides when it refills
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_ok      <= 1'b0;
                        r_pop_key <= '0;
                        r_pop_pay <= '0;
                        r_launch  <= 1'b1;
                        r_state   <= S_SCAN;
                        case (i_func)
                            FUNC_PUSH: begin
                                if (r_count < CAP_C) begin
                                    r_count <= r_count + 1'b1;
                                    r_ok    <= 1'b1;
                                end
                            end
                            FUNC_POP: begin
                                if (r_count != '0) begin
                                    r_state <= S_FIND;
                                end
                            end
                            FUNC_CLEAR: begin
                                r_count <= '0;
                                r_ok    <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FIND: begin
                    if (w_tv[CAPACITY]) begin
                        r_pop_key <= w_fk[CAPACITY];
                        r_pop_pay <= w_fp[CAPACITY];
                        r_rm_idx  <= w_fi[CAPACITY];
                        r_state   <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    // cells close the gap at this edge
                    r_count  <= r_count - 1'b1;
                    r_ok     <= 1'b1;
                    r_launch <= 1'b1;
                    r_state  <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_tv[CAPACITY]) begin
                        r_fk    <= w_th[CAPACITY] ? w_fk[CAPACITY] : '0;
                        r_fp    <= w_th[CAPACITY] ? w_fp[CAPACITY] : '0;
                        r_bk    <= w_th[CAPACITY] ? w_bk[CAPACITY] : '0;
                        r_bp    <= w_th[CAPACITY] ? w_bp[CAPACITY] : '0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_ov      <= 1'b1;
                        r_o_ok    <= r_ok;
                        r_o_pk    <= r_pop_key;
                        r_o_pp    <= r_pop_pay;
                        r_o_fk    <= r_fk;
                        r_o_fp    <= r_fp;
                        r_o_bk    <= r_bk;
                        r_o_bp    <= r_bp;
                        r_o_count <= r_count;
                        r_o_empty <= (r_count == '0);
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_ov;
    assign o_ok             = r_o_ok;
    assign o_out_priority   = r_o_pk;
    assign o_out_payload    = r_o_pp;
    assign o_front_priority = r_o_fk;
    assign o_front_payload  = r_o_fp;
    assign o_back_priority  = r_o_bk;
    assign o_back_payload   = r_o_bp;
    assign o_count          = r_o_count;
    assign o_empty_res      = r_o_empty;

    // count never runs past the chain length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    // the wave only comes out of the chain while the sequencer waits for it
    a_wave_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tv[CAPACITY] |-> (r_state == S_FIND || r_state == S_SCAN))
        else $error("scan wave finished outside a scan");

    // a close-up only follows a find on a non-empty queue
    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_count != '0 && $past(r_state) == S_FIND))
        else $error("close-up without a found entry");

    // a scan is never launched twice in a row
    a_launch_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch |=> !r_launch)
        else $error("scan launched twice in a row");

    // a result carries a consistent count and empty flag
    a_result_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o_empty == (r_o_count == '0)))
        else $error("empty flag disagrees with count");

endmodule

[tb/stable_priority_queue_unit_test.sv]
// Self-checking testbench for stable_priority_queue_unit: handshaked stimulus, result predictor.
module stable_priority_queue_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int PRIORITY_BITS = DEF_PRIORITY_BITS;
    localparam int PAYLOAD_BITS  = DEF_PAYLOAD_BITS;
    localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

    // Code 3 is not decoded by the block: it must report status with ok low.
    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

    localparam logic ORDER_ASC  = 1'b0;
    localparam logic ORDER_DESC = 1'b1;

    // A successful pop is the slowest item; a little slack on top.
    localparam int SETTLE_CYCLES  = 2 * CAPACITY + 5 + 20;
    // Cycles with no handshake of any kind before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [PRIORITY_BITS-1:0] PRIO_MAX = '1;
    localparam logic [PAYLOAD_BITS-1:0]  PAY_MAX  = '1;

    typedef struct packed {
        logic [FUNC_BITS-1:0]     func;
        logic [PRIORITY_BITS-1:0] prio;
        logic [PAYLOAD_BITS-1:0]  pay;
    } t_queue_op;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [PAYLOAD_BITS-1:0]  pay;
    } t_slot;

    typedef struct packed {
        logic                     ok;
        logic [PRIORITY_BITS-1:0] out_prio;
        logic [PAYLOAD_BITS-1:0]  out_pay;
        logic [PRIORITY_BITS-1:0] front_prio;
        logic [PAYLOAD_BITS-1:0]  front_pay;
        logic [PRIORITY_BITS-1:0] back_prio;
        logic [PAYLOAD_BITS-1:0]  back_pay;
        logic [COUNT_BITS-1:0]    count;
        logic                     empty;
    } t_queue_status;

    // Random traffic mixes: fill toward capacity, drain toward empty, or balanced.
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_traffic_mix;

    // DUT ports; every input starts at a known value
    logic                     i_clk;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_valid   = 1'b0;
    logic                     o_cfg_ready;
    logic                     i_cfg_data    = ORDER_ASC;
    logic                     i_in_valid    = 1'b0;
    logic                     o_in_stall;
    logic [FUNC_BITS-1:0]     i_func        = FUNC_PUSH;
    logic [PRIORITY_BITS-1:0] i_in_priority = '0;
    logic [PAYLOAD_BITS-1:0]  i_in_payload  = '0;
    logic                     o_out_valid;
    logic                     i_out_stall   = 1'b0;
    logic                     o_ok;
    logic [PRIORITY_BITS-1:0] o_out_priority;
    logic [PAYLOAD_BITS-1:0]  o_out_payload;
    logic [PRIORITY_BITS-1:0] o_front_priority;
    logic [PAYLOAD_BITS-1:0]  o_front_payload;
    logic [PRIORITY_BITS-1:0] o_back_priority;
    logic [PAYLOAD_BITS-1:0]  o_back_payload;
    logic [COUNT_BITS-1:0]    o_count;
    logic                     o_empty_res;

    // Stimulus waiting for the driver, and predicted status items waiting for the DUT.
    t_queue_op     ops_to_send[$];
    t_queue_status status_due[$];

    // Predictor state: entries in arrival order plus its own copy of the order register.
    t_slot held[$];
    logic  serve_desc = ORDER_ASC;

    int mismatches = 0;

    stable_priority_queue_unit #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_in_priority    (i_in_priority),
        .i_in_payload     (i_in_payload),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_ok             (o_ok),
        .o_out_priority   (o_out_priority),
        .o_out_payload    (o_out_payload),
        .o_front_priority (o_front_priority),
        .o_front_payload  (o_front_payload),
        .o_back_priority  (o_back_priority),
        .o_back_payload   (o_back_payload),
        .o_count          (o_count),
        .o_empty_res      (o_empty_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Key a leaves strictly ahead of key b under the current order.
    function automatic logic served_first(logic [PRIORITY_BITS-1:0] a,
                                          logic [PRIORITY_BITS-1:0] b);
        return serve_desc ? (a > b) : (a < b);
    endfunction

    // Front: first arrival of the first-served key (strict compare keeps the earliest tie).
    function automatic int front_slot();
        int best;
        best = 0;
        for (int i = 1; i < held.size(); i++) begin
            if (served_first(held[i].prio, held[best].prio)) best = i;
        end
        return best;
    endfunction

    // Back: last arrival of the last-served key (non-strict compare moves to later ties).
    function automatic int back_slot();
        int best;
        best = 0;
        for (int i = 1; i < held.size(); i++) begin
            if (!served_first(held[i].prio, held[best].prio)) best = i;
        end
        return best;
    endfunction

    // Apply one accepted op to the predictor and return the status it must produce.
    function automatic t_queue_status apply_queue_op(t_queue_op op);
        t_queue_status s;
        t_slot         slot;
        int            f;
        int            b;
        s = '0;
        case (op.func)
            FUNC_PUSH: begin
                // full queue: push refused, nothing changes
                if (held.size() < CAPACITY) begin
                    slot.prio = op.prio;
                    slot.pay  = op.pay;
                    held.push_back(slot);
                    s.ok = 1'b1;
                end
            end
            FUNC_POP: begin
                // empty queue: pop refused, popped fields stay zero
                if (held.size() > 0) begin
                    f = front_slot();
                    s.out_prio = held[f].prio;
                    s.out_pay  = held[f].pay;
                    held.delete(f);
                    s.ok = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                held.delete();
                s.ok = 1'b1;
            end
            default: ; // unused code: ok low, status only
        endcase
        // front/back read as zero while empty
        if (held.size() > 0) begin
            f = front_slot();
            b = back_slot();
            s.front_prio = held[f].prio;
            s.front_pay  = held[f].pay;
            s.back_prio  = held[b].prio;
            s.back_pay   = held[b].pay;
        end
        s.count = COUNT_BITS'(held.size());
        s.empty = (held.size() == 0);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of items with random gaps; holds the item until accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        t_queue_op nxt;
        t_queue_op taken;
        int        burst_left;
        int        gap_left;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // pre-edge port values: this is the item the DUT takes at this edge
            if (i_in_valid && !o_in_stall) begin
                taken.func = i_func;
                taken.prio = i_in_priority;
                taken.pay  = i_in_payload;
                status_due.push_back(apply_queue_op(taken));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (ops_to_send.size() > 0) begin
                    nxt = ops_to_send.pop_front();
                    i_func        <= nxt.func;
                    i_in_priority <= nxt.prio;
                    i_in_payload  <= nxt.pay;
                    i_in_valid    <= 1'b1;
                    if (burst_left <= 1) begin
                        // new burst; about a third of them follow back to back
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction,
    // and drive the output stall with its own run-length pattern.
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_queue_status want;
        int            stall_left;
        int            free_left;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
            free_left  = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (status_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual ok=%b count=%0d",
                             $time, o_ok, o_count);
                end else begin
                    want = status_due.pop_front();
                    check_field("ok",             64'(want.ok),         64'(o_ok));
                    check_field("out_priority",   64'(want.out_prio),   64'(o_out_priority));
                    check_field("out_payload",    64'(want.out_pay),    64'(o_out_payload));
                    check_field("front_priority", 64'(want.front_prio),
                                64'(o_front_priority));
                    check_field("front_payload",  64'(want.front_pay),  64'(o_front_payload));
                    check_field("back_priority",  64'(want.back_prio),  64'(o_back_priority));
                    check_field("back_payload",   64'(want.back_pay),   64'(o_back_payload));
                    check_field("count",          64'(want.count),      64'(o_count));
                    check_field("empty_res",      64'(want.empty),      64'(o_empty_res));
                end
            end
            // stall runs alternate with free stretches, both of random length;
            // a quarter of the free stretches skip the stall altogether
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (free_left > 0) begin
                free_left--;
                i_out_stall <= 1'b0;
            end else begin
                free_left  = $urandom_range(0, 40);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake resets the idle count.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic enqueue_op(input logic [FUNC_BITS-1:0] func,
                              input logic [PRIORITY_BITS-1:0] prio,
                              input logic [PAYLOAD_BITS-1:0] pay);
        t_queue_op op;
        op.func = func;
        op.prio = prio;
        op.pay  = pay;
        ops_to_send.push_back(op);
    endtask

    // Block is idle once every queued item went in and every result came back.
    // Sampled at the falling edge so driver and monitor updates have settled.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (ops_to_send.size() > 0 || i_in_valid || status_due.size() > 0);
    endtask

    task automatic write_order(input logic desc);
        @(posedge i_clk);
        i_cfg_data  <= desc;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        serve_desc = desc;
        i_cfg_valid <= 1'b0;
    endtask

    // Keys mostly from small bands so ties are common at both ends of the range.
    function automatic logic [PRIORITY_BITS-1:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return PRIORITY_BITS'($urandom_range(0, 7));
        if (r < 60) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return PRIORITY_BITS'(1);
                2:       return PRIO_MAX - 1'b1;
                default: return PRIO_MAX;
            endcase
        end
        if (r < 70) return PRIO_MAX - PRIORITY_BITS'($urandom_range(0, 7));
        return PRIORITY_BITS'($urandom);
    endfunction

    function automatic logic [PAYLOAD_BITS-1:0] pick_pay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return PAY_MAX;
        return PAYLOAD_BITS'($urandom);
    endfunction

    function automatic logic [FUNC_BITS-1:0] pick_func(t_traffic_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  return (r < 92) ? FUNC_PUSH : (r < 97) ? FUNC_POP : FUNC_UNUSED;
            MIX_DRAIN: return (r < 85) ? FUNC_POP : (r < 97) ? FUNC_PUSH : FUNC_UNUSED;
            default:   return (r < 50) ? FUNC_PUSH : (r < 90) ? FUNC_POP :
                              (r < 95) ? FUNC_CLEAR : FUNC_UNUSED;
        endcase
    endfunction

    initial begin : stimulus
        t_traffic_mix plan[6];
        int           plan_len[6];
        plan     = '{MIX_FILL, MIX_DRAIN, MIX_FILL, MIX_BALANCED, MIX_FILL, MIX_DRAIN};
        plan_len = '{90, 90, 90, 80, 90, 90};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_order(ORDER_ASC);

        // Directed, ascending: empty cases, key/payload extremes, ties, clear.
        enqueue_op(FUNC_POP,    '0, '0);                 // pop on empty
        enqueue_op(FUNC_UNUSED, PRIO_MAX, PAY_MAX);      // unused code, empty queue
        enqueue_op(FUNC_PUSH,   '0, PAY_MAX);
        enqueue_op(FUNC_PUSH,   PRIO_MAX, '0);
        enqueue_op(FUNC_PUSH,   16'd5, 32'hA000_0001);   // three equal keys
        enqueue_op(FUNC_PUSH,   16'd5, 32'hA000_0002);
        enqueue_op(FUNC_PUSH,   16'd5, 32'hA000_0003);
        enqueue_op(FUNC_UNUSED, 16'h5A5A, 32'h5A5A_A5A5); // unused code with entries held
        enqueue_op(FUNC_POP,    '0, '0);
        enqueue_op(FUNC_POP,    '0, '0);
        enqueue_op(FUNC_POP,    '0, '0);
        enqueue_op(FUNC_CLEAR,  16'h1234, 32'h1234_5678);
        enqueue_op(FUNC_POP,    '0, '0);                 // pop right after clear
        enqueue_op(FUNC_CLEAR,  '0, '0);                 // clear on empty
        enqueue_op(FUNC_PUSH,   PRIO_MAX, 32'hB000_0001);
        enqueue_op(FUNC_PUSH,   16'd3, 32'hB000_0002);
        enqueue_op(FUNC_PUSH,   PRIO_MAX, 32'hB000_0003);
        enqueue_op(FUNC_PUSH,   16'd3, 32'hB000_0004);
        wait_idle();

        // Flip order with four entries held: front and back swap ends.
        write_order(ORDER_DESC);
        enqueue_op(FUNC_UNUSED, '0, '0);
        enqueue_op(FUNC_POP,    '0, '0);
        enqueue_op(FUNC_PUSH,   16'h8000, 32'hC000_0001);
        enqueue_op(FUNC_POP,    '0, '0);
        wait_idle();

        // Random phases; the order register alternates with entries usually held.
        for (int ph = 0; ph < 6; ph++) begin
            write_order((ph % 2 == 0) ? ORDER_ASC : ORDER_DESC);
            for (int n = 0; n < plan_len[ph]; n++) begin
                enqueue_op(pick_func(plan[ph]), pick_prio(), pick_pay());
            end
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
